// File: rtl/bmmdr_pkg.sv
`default_nettype none

package bmmdr_pkg;

  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [15:0] StallLimitRst   = 16'd70;
  localparam logic [7:0]  ShortTicksRst   = 8'd8;
  localparam logic [7:0]  LongTicksRst    = 8'd200;
  localparam logic [7:0]  StartCeilRst    = 8'd46;
  localparam logic [7:0]  CeilModeOneRst  = 8'd54;
  localparam logic [7:0]  CeilModeTwoRst  = 8'd30;
  localparam logic [7:0]  CeilModeThrRst  = 8'd14;
  localparam logic [7:0]  CeilModeFourRst = 8'd5;

  localparam logic [7:0] DutyFloor = 8'd2;
  localparam logic [7:0] DutyStart = 8'd1;
  localparam logic [7:0] HoldMax   = 8'd255;

  localparam logic [2:0] ModeStopped = 3'd0;
  localparam logic [2:0] ModeOne     = 3'd1;
  localparam logic [2:0] ModeTwo     = 3'd2;
  localparam logic [2:0] ModeThree   = 3'd3;
  localparam logic [2:0] ModeFour    = 3'd4;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_CLICK = 2'd1,
    KEY_LONG  = 2'd2
  } key_event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_STALL_LIMIT = 3'd0,
    REG_SHORT_TICKS = 3'd1,
    REG_LONG_TICKS  = 3'd2,
    REG_START_CEIL  = 3'd3,
    REG_CEIL_ONE    = 3'd4,
    REG_CEIL_TWO    = 3'd5,
    REG_CEIL_THREE  = 3'd6,
    REG_CEIL_FOUR   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] short_ticks;
    logic [7:0] long_ticks;
  } key_cfg_t;

endpackage

`default_nettype wire

// File: rtl/bmmdr_key.sv
`default_nettype none

module bmmdr_key
  import bmmdr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        step_i,
  input  wire        key_down_i,
  input  key_cfg_t   cfg_i,
  output key_event_e event_o
);

  logic [7:0] hold_q, hold_d;
  logic       long_rep_q, long_rep_d;
  logic [7:0] hold_inc;

  always_comb begin
    hold_d     = 8'd0;
    long_rep_d = long_rep_q;
    event_o    = KEY_NONE;
    hold_inc   = (hold_q < HoldMax) ? hold_q + 8'd1 : hold_q;
    if (key_down_i) begin
      hold_d = hold_inc;
      if (hold_inc >= cfg_i.long_ticks) begin
        hold_d = cfg_i.long_ticks;
        if (!long_rep_q) begin
          long_rep_d = 1'b1;
          event_o    = KEY_LONG;
        end
      end
    end else if (hold_q >= cfg_i.long_ticks) begin
      long_rep_d = 1'b0;
    end else if (hold_q >= cfg_i.short_ticks) begin
      event_o = KEY_CLICK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q     <= 8'd0;
      long_rep_q <= 1'b0;
    end else if (step_i) begin
      hold_q     <= hold_d;
      long_rep_q <= long_rep_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/button_mode_motor_duty_ramp_unit.sv
`default_nettype none

// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  key_down, charging, speed_period
// m_axis   out  m_axis_tvalid/m_axis_tready  running, mode, drive_duty, key_event
// cfg      in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each request passes an input register and then a result register. One request
// is accepted per cycle while the result side is not stalled; the state update
// happens as a request moves into the result register. A stalled result holds
// both stages and deasserts s_axis_tready only when full.
// Reset clears the mode, duty and key state and loads the default settings.

module button_mode_motor_duty_ramp_unit
  import bmmdr_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  // [0] key_down, [1] charging, [17:2] speed_period, [23:18] zero
  input  wire  [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  // [0] running, [3:1] mode, [11:4] drive_duty, [13:12] key_event, [15:14] zero
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire  [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire  [CfgDataWidth-1:0] cfg_data_i
);

  logic [15:0] stall_limit_q;
  logic [7:0]  short_ticks_q, long_ticks_q, start_ceil_q;
  logic [7:0]  ceil_one_q, ceil_two_q, ceil_three_q, ceil_four_q;

  logic        in_valid_q;
  logic        in_key_q, in_chg_q;
  logic [15:0] in_period_q;
  logic        out_valid_q;
  logic [OutDataWidth-1:0] out_data_q;

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  ceil_q, ceil_d;

  logic        advance;
  logic        key_step;
  key_cfg_t    key_cfg;
  key_event_e  key_event;
  logic [8:0]  duty_inc;
  logic        run_d;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_limit_q <= StallLimitRst;
      short_ticks_q <= ShortTicksRst;
      long_ticks_q  <= LongTicksRst;
      start_ceil_q  <= StartCeilRst;
      ceil_one_q    <= CeilModeOneRst;
      ceil_two_q    <= CeilModeTwoRst;
      ceil_three_q  <= CeilModeThrRst;
      ceil_four_q   <= CeilModeFourRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STALL_LIMIT: stall_limit_q <= cfg_data_i[15:0];
        REG_SHORT_TICKS: short_ticks_q <= cfg_data_i[7:0];
        REG_LONG_TICKS:  long_ticks_q  <= cfg_data_i[7:0];
        REG_START_CEIL:  start_ceil_q  <= cfg_data_i[7:0];
        REG_CEIL_ONE:    ceil_one_q    <= cfg_data_i[7:0];
        REG_CEIL_TWO:    ceil_two_q    <= cfg_data_i[7:0];
        REG_CEIL_THREE:  ceil_three_q  <= cfg_data_i[7:0];
        REG_CEIL_FOUR:   ceil_four_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign key_cfg.short_ticks = short_ticks_q;
  assign key_cfg.long_ticks  = long_ticks_q;
  assign key_step            = advance && !in_chg_q;

  bmmdr_key u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (key_step),
    .key_down_i (in_key_q),
    .cfg_i      (key_cfg),
    .event_o    (key_event)
  );

  always_comb begin
    mode_d   = mode_q;
    duty_d   = duty_q;
    ceil_d   = ceil_q;
    duty_inc = 9'd0;
    if (in_chg_q) begin
      mode_d = ModeStopped;
      duty_d = 8'd0;
    end else begin
      if (key_event == KEY_CLICK && mode_q != ModeStopped) begin
        mode_d = (mode_q == ModeFour) ? ModeOne : mode_q + 3'd1;
        duty_d = DutyStart;
        case (mode_d)
          ModeOne:   ceil_d = ceil_one_q;
          ModeTwo:   ceil_d = ceil_two_q;
          ModeThree: ceil_d = ceil_three_q;
          default:   ceil_d = ceil_four_q;
        endcase
      end else if (key_event == KEY_LONG) begin
        if (mode_q != ModeStopped) begin
          mode_d = ModeStopped;
          duty_d = 8'd0;
        end else begin
          mode_d = ModeOne;
          ceil_d = start_ceil_q;
          duty_d = DutyStart;
        end
      end
      if (mode_d != ModeStopped) begin
        if (in_period_q > stall_limit_q) begin
          if (duty_d > DutyFloor) begin
            duty_d = duty_d - 8'd1;
          end
        end else begin
          duty_inc = {1'b0, duty_d} + 9'd1;
          duty_d   = (duty_inc >= {1'b0, ceil_d}) ? ceil_d : duty_inc[7:0];
        end
      end
    end
  end

  assign run_d = (mode_d != ModeStopped);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeStopped;
      duty_q      <= 8'd0;
      ceil_q      <= 8'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        duty_q      <= duty_d;
        ceil_q      <= ceil_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_key_q    <= s_axis_tdata[0];
      in_chg_q    <= s_axis_tdata[1];
      in_period_q <= s_axis_tdata[17:2];
    end
    if (advance) begin
      out_data_q <= {2'b00, (in_chg_q ? KEY_NONE : key_event), (run_d ? duty_d : 8'd0),
                     mode_d, run_d};
    end
  end

endmodule

`default_nettype wire
